### hw/rtl/mcwdt_pkg.sv
// Shared definitions for the multi-channel watchdog: sizes, action and status codes,
// and the command/status bundles between controller and datapath. No dependencies.
package mcwdt_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MAX_RESULTS  = 8;
   localparam int EXP_PTR_W    = $clog2(MAX_RESULTS);
   localparam int EXP_CNT_W    = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] ACT_ADD     = 3'd0;
   localparam logic [2:0] ACT_DELETE  = 3'd1;
   localparam logic [2:0] ACT_FEED    = 3'd2;
   localparam logic [2:0] ACT_SUSPEND = 3'd3;
   localparam logic [2:0] ACT_RESUME  = 3'd4;
   localparam logic [2:0] ACT_TICK    = 3'd5;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_ZERO_PERIOD = 3'd1;
   localparam logic [2:0] ST_NO_FREE     = 3'd2;
   localparam logic [2:0] ST_RANGE       = 3'd3;
   localparam logic [2:0] ST_INACTIVE    = 3'd4;

   localparam logic [3:0] NO_CHANNEL = 4'd8;

   typedef struct packed {
      logic latch;      // capture the request word
      logic init;       // decode the action, do single-step work
      logic idx_clear;  // restart the channel scan
      logic find;       // search for a free channel
      logic tick;       // count down one channel
      logic resume;     // reload one channel
      logic soon;       // fold one channel into the soonest search
      logic emit;       // send one result word
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       period_zero;
      logic       running;
      logic       idx_last;
      logic       slot_free;
      logic       emit_last;
   } dp_sts_type;

endpackage

### hw/rtl/mcwdt_ctrl.sv
// Sequencing state machine of the multi-channel watchdog.
// Depends on mcwdt_pkg for the command and status bundles and the action codes.
module mcwdt_ctrl
   import mcwdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_FIND   = 3'd2;
   localparam logic [2:0] S_TICK   = 3'd3;
   localparam logic [2:0] S_RESUME = 3'd4;
   localparam logic [2:0] S_SOON   = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.init      = 1'b1;
            cmd.idx_clear = 1'b1;
            unique case (sts.action)
               ACT_ADD:    state_in = sts.period_zero ? S_SOON : S_FIND;
               ACT_RESUME: state_in = S_RESUME;
               ACT_TICK:   state_in = sts.running ? S_TICK : S_SOON;
               default:    state_in = S_SOON;
            endcase
         end
         S_FIND: begin
            cmd.find = 1'b1;
            if (sts.slot_free || sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_SOON;
            end
         end
         S_TICK: begin
            cmd.tick = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_SOON;
            end
         end
         S_RESUME: begin
            cmd.resume = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_SOON;
            end
         end
         S_SOON: begin
            cmd.soon = 1'b1;
            if (sts.idx_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECODE))
      else $error("accepted word did not enter decode");

   a_find_on_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> (sts.action == ACT_ADD))
      else $error("free-channel search outside an add");

   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && sts.emit_last) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after the final word");

endmodule

### hw/rtl/mcwdt_dp.sv
// Datapath of the multi-channel watchdog: channel table, scan index, expiry list,
// soonest search and the result output register. Depends on mcwdt_pkg.
module mcwdt_dp
   import mcwdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_sts_type   sts,
   input  logic [2:0]   req_action,
   input  logic [7:0]   req_channel,
   input  logic [31:0]  req_period,
   output logic         rsp_valid,
   output logic [2:0]   rsp_status,
   output logic [2:0]   rsp_channel_out,
   output logic         rsp_timed_out,
   output logic [3:0]   rsp_soonest_channel,
   output logic [31:0]  rsp_soonest_remaining,
   output logic         rsp_last
);

   logic [2:0]  action_ff, action_in;
   logic [7:0]  channel_ff, channel_in;
   logic [31:0] period_ff, period_in;

   logic        active_ff [NUM_CHANNELS];
   logic        active_in [NUM_CHANNELS];
   logic [31:0] reload_ff [NUM_CHANNELS];
   logic [31:0] reload_in [NUM_CHANNELS];
   logic [31:0] remain_ff [NUM_CHANNELS];
   logic [31:0] remain_in [NUM_CHANNELS];
   logic        running_ff, running_in;

   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     exp_list_ff [MAX_RESULTS];
   logic [IDX_W-1:0]     exp_list_in [MAX_RESULTS];
   logic [EXP_CNT_W-1:0] exp_cnt_ff, exp_cnt_in;
   logic [EXP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   logic [2:0]       status_ff, status_in;
   logic [2:0]       chan_out_ff, chan_out_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      best_rem_ff, best_rem_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_chan_ff, rsp_chan_in;
   logic        rsp_to_ff, rsp_to_in;
   logic [3:0]  rsp_soon_ch_ff, rsp_soon_ch_in;
   logic [31:0] rsp_soon_rem_ff, rsp_soon_rem_in;
   logic        rsp_last_ff, rsp_last_in;

   logic             ch_range_bad;
   logic [IDX_W-1:0] ch_idx;
   logic [31:0]      tick_val;
   logic             emit_last;

   assign ch_range_bad = (channel_ff >= 8'(NUM_CHANNELS));
   assign ch_idx       = IDX_W'(channel_ff);
   assign tick_val     = (remain_ff[idx_ff] == 32'd0) ? 32'd0 : remain_ff[idx_ff] - 32'd1;
   assign emit_last    = (exp_cnt_ff == '0) ||
                         (EXP_CNT_W'(rd_ptr_ff) == exp_cnt_ff - EXP_CNT_W'(1));

   assign sts.action      = action_ff;
   assign sts.period_zero = (period_ff == 32'd0);
   assign sts.running     = running_ff;
   assign sts.idx_last    = (idx_ff == IDX_W'(NUM_CHANNELS - 1));
   assign sts.slot_free   = !active_ff[idx_ff];
   assign sts.emit_last   = emit_last;

   always_comb begin
      action_in      = action_ff;
      channel_in     = channel_ff;
      period_in      = period_ff;
      active_in      = active_ff;
      reload_in      = reload_ff;
      remain_in      = remain_ff;
      running_in     = running_ff;
      idx_in         = idx_ff;
      exp_list_in    = exp_list_ff;
      exp_cnt_in     = exp_cnt_ff;
      rd_ptr_in      = rd_ptr_ff;
      status_in      = status_ff;
      chan_out_in    = chan_out_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_rem_in    = best_rem_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_chan_in    = rsp_chan_ff;
      rsp_to_in      = rsp_to_ff;
      rsp_soon_ch_in = rsp_soon_ch_ff;
      rsp_soon_rem_in = rsp_soon_rem_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.latch) begin
         action_in  = req_action;
         channel_in = req_channel;
         period_in  = req_period;
      end

      if (cmd.init) begin
         status_in   = ST_OK;
         chan_out_in = 3'd0;
         exp_cnt_in  = '0;
         rd_ptr_in   = '0;
         unique case (action_ff) inside
            ACT_ADD: begin
               if (period_ff == 32'd0) begin
                  status_in = ST_ZERO_PERIOD;
               end
            end
            ACT_DELETE, ACT_FEED: begin
               if (ch_range_bad) begin
                  status_in = ST_RANGE;
               end else if (!active_ff[ch_idx]) begin
                  status_in = ST_INACTIVE;
               end else if (action_ff == ACT_DELETE) begin
                  active_in[ch_idx] = 1'b0;
                  reload_in[ch_idx] = 32'd0;
                  remain_in[ch_idx] = 32'd0;
               end else begin
                  remain_in[ch_idx] = reload_ff[ch_idx];
               end
            end
            ACT_SUSPEND: running_in = 1'b0;
            ACT_RESUME:  running_in = 1'b1;
            default: ;
         endcase
      end

      if (cmd.find) begin
         if (!active_ff[idx_ff]) begin
            active_in[idx_ff] = 1'b1;
            reload_in[idx_ff] = period_ff;
            remain_in[idx_ff] = period_ff;
            chan_out_in       = 3'(idx_ff);
         end else if (sts.idx_last) begin
            status_in = ST_NO_FREE;
         end
      end

      if (cmd.tick && active_ff[idx_ff]) begin
         remain_in[idx_ff] = tick_val;
         // report at most MAX_RESULTS expiries; the rest stay parked at zero
         if (tick_val == 32'd0 && exp_cnt_ff < EXP_CNT_W'(MAX_RESULTS)) begin
            active_in[idx_ff]                    = 1'b0;
            exp_list_in[EXP_PTR_W'(exp_cnt_ff)]  = idx_ff;
            exp_cnt_in                           = exp_cnt_ff + 1'b1;
         end
      end

      if (cmd.resume && active_ff[idx_ff]) begin
         remain_in[idx_ff] = reload_ff[idx_ff];
      end

      if (cmd.soon && active_ff[idx_ff] && (!found_ff || remain_ff[idx_ff] < best_rem_ff)) begin
         found_in    = 1'b1;
         best_idx_in = idx_ff;
         best_rem_in = remain_ff[idx_ff];
      end

      if (cmd.find || cmd.tick || cmd.resume || cmd.soon) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.idx_clear) begin
         idx_in   = '0;
         found_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_last_in     = emit_last;
         rsp_soon_ch_in  = found_ff ? 4'(best_idx_ff) : NO_CHANNEL;
         rsp_soon_rem_in = found_ff ? best_rem_ff : 32'd0;
         if (exp_cnt_ff == '0) begin
            rsp_status_in = status_ff;
            rsp_chan_in   = chan_out_ff;
            rsp_to_in     = 1'b0;
         end else begin
            rsp_status_in = ST_OK;
            rsp_chan_in   = 3'(exp_list_ff[rd_ptr_ff]);
            rsp_to_in     = 1'b1;
         end
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '{default: 1'b0};
         running_ff   <= 1'b1;
         idx_ff       <= '0;
         exp_cnt_ff   <= '0;
         rd_ptr_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         running_ff   <= running_in;
         idx_ff       <= idx_in;
         exp_cnt_ff   <= exp_cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff       <= action_in;
      channel_ff      <= channel_in;
      period_ff       <= period_in;
      reload_ff       <= reload_in;
      remain_ff       <= remain_in;
      exp_list_ff     <= exp_list_in;
      status_ff       <= status_in;
      chan_out_ff     <= chan_out_in;
      best_idx_ff     <= best_idx_in;
      best_rem_ff     <= best_rem_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_chan_ff     <= rsp_chan_in;
      rsp_to_ff       <= rsp_to_in;
      rsp_soon_ch_ff  <= rsp_soon_ch_in;
      rsp_soon_rem_ff <= rsp_soon_rem_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_channel_out       = rsp_chan_ff;
   assign rsp_timed_out         = rsp_to_ff;
   assign rsp_soonest_channel   = rsp_soon_ch_ff;
   assign rsp_soonest_remaining = rsp_soon_rem_ff;
   assign rsp_last              = rsp_last_ff;

   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      exp_cnt_ff <= EXP_CNT_W'(MAX_RESULTS))
      else $error("expiry list overflow");

   a_timeout_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_to_ff) |-> (rsp_status_ff == ST_OK))
      else $error("timeout word carries an error status");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("gap inside a result burst");

endmodule

### hw/rtl/multi_channel_watchdog_top.sv
// Top level of the multi-channel watchdog: joins the sequencer and the datapath.
// Depends on mcwdt_pkg, mcwdt_ctrl and mcwdt_dp.
// Sequence: decode, a table scan for add, tick and resume (add stops at the first free
//   channel), a soonest scan over all channels, then one result word per emit step.
//   A new word is taken only once the last result word is out; the table scans visit
//   one channel per cycle. Results cannot be stalled.
// Reset (synchronous): all channels inactive, watchdog running, no result pending.
module multi_channel_watchdog_top
   import mcwdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_channel,
   input  logic [31:0] req_period,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_channel_out,
   output logic        rsp_timed_out,
   output logic [3:0]  rsp_soonest_channel,
   output logic [31:0] rsp_soonest_remaining,
   output logic        rsp_last
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   mcwdt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mcwdt_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_action            (req_action),
      .req_channel           (req_channel),
      .req_period            (req_period),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_channel_out       (rsp_channel_out),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_soonest_channel   (rsp_soonest_channel),
      .rsp_soonest_remaining (rsp_soonest_remaining),
      .rsp_last              (rsp_last)
   );

endmodule

### bench/multi_channel_watchdog_top_tb.sv
// Self-checking bench for multi_channel_watchdog_top: queued action words, a cycle-level
// driver and monitor, and an in-bench watchdog predictor. Depends on mcwdt_pkg and the RTL.
module multi_channel_watchdog_top_tb;
   import mcwdt_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 60;
   localparam int RANDOM_ITEMS = 348;

   // action codes the block ignores
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   typedef struct {
      logic [2:0]  action;
      logic [7:0]  channel;
      logic [31:0] period;
      int          gap;
      bit          drain;
   } wdt_cmd_type;

   typedef struct {
      logic [2:0]  status;
      logic [2:0]  channel_out;
      logic        timed_out;
      logic [3:0]  soonest_channel;
      logic [31:0] soonest_remaining;
      logic        last;
   } wdt_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_channel = '0;
   logic [31:0] req_period = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_channel_out;
   logic        rsp_timed_out;
   logic [3:0]  rsp_soonest_channel;
   logic [31:0] rsp_soonest_remaining;
   logic        rsp_last;

   wdt_cmd_type    action_queue [$];
   wdt_report_type expected_reports [$];
   wdt_cmd_type    cur_cmd;
   wdt_report_type want;
   bit          sending;
   bit          waiting;
   int          gap_left;
   int          calm_left;
   int          items_queued;
   int          idle_cycles;
   int          error_count;

   // predicted watchdog state
   bit          chan_active [NUM_CHANNELS];
   logic [31:0] chan_reload [NUM_CHANNELS];
   logic [31:0] chan_count  [NUM_CHANNELS];
   bit          wd_running;

   multi_channel_watchdog_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_channel           (req_channel),
      .req_period            (req_period),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_channel_out       (rsp_channel_out),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_soonest_channel   (rsp_soonest_channel),
      .rsp_soonest_remaining (rsp_soonest_remaining),
      .rsp_last              (rsp_last)
   );

   always #2 clock = ~clock;

   // Apply one accepted word to the predicted state and queue the result words it causes.
   task automatic advance_watchdog(input wdt_cmd_type cmd);
      wdt_report_type batch [$];
      wdt_report_type rep;
      int          slot;
      bit          found;
      logic [3:0]  best_chan;
      logic [31:0] best_count;
      rep = '{default: '0};
      slot = -1;
      found = 0;
      best_chan = NO_CHANNEL;
      best_count = '0;
      case (cmd.action)
         ACT_ADD: begin
            if (cmd.period == 0) begin
               rep.status = ST_ZERO_PERIOD;
            end else begin
               for (int i = 0; i < NUM_CHANNELS; i++)
                  if (!chan_active[i] && slot < 0) slot = i;
               if (slot < 0) begin
                  rep.status = ST_NO_FREE;
               end else begin
                  chan_active[slot] = 1;
                  chan_reload[slot] = cmd.period;
                  chan_count[slot]  = cmd.period;
                  rep.channel_out   = 3'(slot);
               end
            end
         end
         ACT_DELETE, ACT_FEED: begin
            if (cmd.channel >= NUM_CHANNELS) begin
               rep.status = ST_RANGE;
            end else if (!chan_active[cmd.channel]) begin
               rep.status = ST_INACTIVE;
            end else if (cmd.action == ACT_DELETE) begin
               chan_active[cmd.channel] = 0;
               chan_reload[cmd.channel] = '0;
               chan_count[cmd.channel]  = '0;
            end else begin
               chan_count[cmd.channel] = chan_reload[cmd.channel];
            end
         end
         ACT_SUSPEND: wd_running = 0;
         ACT_RESUME: begin
            for (int i = 0; i < NUM_CHANNELS; i++)
               if (chan_active[i]) chan_count[i] = chan_reload[i];
            wd_running = 1;
         end
         ACT_TICK: begin
            if (wd_running) begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (chan_active[i]) begin
                     // a count already at zero holds at zero and expires
                     if (chan_count[i] != 0) chan_count[i]--;
                     if (chan_count[i] == 0 && batch.size() < MAX_RESULTS) begin
                        chan_active[i] = 0;
                        rep.channel_out = 3'(i);
                        rep.timed_out = 1'b1;
                        batch.push_back(rep);
                     end
                  end
               end
               rep.channel_out = '0;
               rep.timed_out = 1'b0;
            end
         end
         default: ;
      endcase
      if (batch.size() == 0) batch.push_back(rep);
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (chan_active[i] && (!found || chan_count[i] < best_count)) begin
            found = 1;
            best_chan = 4'(i);
            best_count = chan_count[i];
         end
      end
      for (int k = 0; k < batch.size(); k++) begin
         batch[k].soonest_channel = best_chan;
         batch[k].soonest_remaining = best_count;
         batch[k].last = (k == batch.size() - 1);
         expected_reports.push_back(batch[k]);
      end
   endtask

   task automatic push_action(input logic [2:0] act, input logic [7:0] chan,
                              input logic [31:0] per);
      wdt_cmd_type cmd;
      int       r;
      r = $urandom_range(0, 99);
      cmd.action = act;
      cmd.channel = chan;
      cmd.period = per;
      cmd.drain = 0;
      if (calm_left > 0) begin
         calm_left--;
         cmd.gap = 0;
      end else if (r < 50) begin
         cmd.gap = 0;
      end else if (r < 85) begin
         cmd.gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         cmd.gap = $urandom_range(4, 12);
      end else begin
         cmd.gap = $urandom_range(20, 60);
      end
      action_queue.push_back(cmd);
      items_queued++;
   endtask

   // Hold the sender until every expected word has come back.
   task automatic push_drain();
      wdt_cmd_type cmd;
      cmd = '{action: ACT_TICK, channel: '0, period: '0, gap: 0, drain: 1};
      action_queue.push_back(cmd);
   endtask

   function automatic logic [31:0] pick_period();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 32'($urandom_range(1, 6));
      if (p < 70) return '0;
      if (p < 80) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_channel();
      if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, NUM_CHANNELS - 1));
      return 8'($urandom_range(NUM_CHANNELS, 255));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         sending = 0;
         waiting = 0;
         gap_left = 0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_active[i] = 0;
            chan_reload[i] = '0;
            chan_count[i] = '0;
         end
         wd_running = 1;
      end else begin
         if (start && !busy) begin
            advance_watchdog(cur_cmd);
            sending = 0;
         end
         if (!sending && !waiting && action_queue.size() > 0) begin
            if (action_queue[0].drain) begin
               // release only once no word is due and none is on the bus
               if (expected_reports.size() == 0 && !rsp_valid) action_queue.delete(0);
            end else begin
               cur_cmd = action_queue.pop_front();
               gap_left = cur_cmd.gap;
               waiting = 1;
            end
         end
         if (waiting) begin
            if (gap_left == 0) begin
               waiting = 0;
               sending = 1;
            end else begin
               gap_left--;
            end
         end
         start <= sending;
         if (sending) begin
            req_action <= cur_cmd.action;
            req_channel <= cur_cmd.channel;
            req_period <= cur_cmd.period;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result word: status %0d channel_out %0d timed_out %0d",
                   rsp_status, rsp_channel_out, rsp_timed_out);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_channel_out !== want.channel_out) begin
               $error("channel_out: expected %0d, actual %0d", want.channel_out,
                      rsp_channel_out);
               error_count++;
            end
            if (rsp_timed_out !== want.timed_out) begin
               $error("timed_out: expected %0d, actual %0d", want.timed_out, rsp_timed_out);
               error_count++;
            end
            if (rsp_soonest_channel !== want.soonest_channel) begin
               $error("soonest_channel: expected %0d, actual %0d", want.soonest_channel,
                      rsp_soonest_channel);
               error_count++;
            end
            if (rsp_soonest_remaining !== want.soonest_remaining) begin
               $error("soonest_remaining: expected %0h, actual %0h", want.soonest_remaining,
                      rsp_soonest_remaining);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // count cycles with no accepted input word
   always @(posedge clock) begin
      if (reset || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
   end

   initial begin
      int r;
      int n_ticks;
      calm_left = 0;
      items_queued = 0;
      error_count = 0;
      idle_cycles = 0;

      push_action(ACT_TICK, 8'd0, 32'd0);            // empty table
      push_action(ACT_ADD, 8'd0, 32'd0);             // zero period
      push_action(ACT_ADD, 8'hFF, 32'd1);
      push_action(ACT_ADD, 8'd0, 32'hFFFF_FFFF);
      push_action(ACT_ADD, 8'd0, 32'd3);
      push_action(ACT_FEED, 8'hFF, 32'd0);           // out of range
      push_action(ACT_DELETE, 8'd8, 32'd0);          // just out of range
      push_action(ACT_DELETE, 8'd5, 32'd0);          // inactive
      push_action(ACT_TICK, 8'd0, 32'd0);            // channel 0 expires
      push_action(ACT_SUSPEND, 8'd0, 32'd0);
      push_action(ACT_TICK, 8'd0, 32'd0);            // no expiry while suspended
      push_action(ACT_SUSPEND, 8'd0, 32'd0);
      push_action(ACT_ADD, 8'd0, 32'd2);             // add while suspended
      push_action(ACT_RESUME, 8'd0, 32'd0);
      push_action(ACT_RESUME, 8'd0, 32'd0);
      for (int c = 0; c < 5; c++) push_action(ACT_ADD, 8'd0, 32'd1);
      push_action(ACT_ADD, 8'd0, 32'd5);             // table full
      push_action(ACT_TICK, 8'd0, 32'd0);            // several expire in one tick
      push_action(ACT_DELETE, 8'd1, 32'd0);
      push_action(ACT_FEED, 8'd2, 32'd0);
      push_action(ACT_SPARE_A, 8'hA5, 32'h5A5A_5A5A);
      push_action(ACT_SPARE_B, 8'h5A, 32'hA5A5_A5A5);
      push_drain();

      r = items_queued;
      while (items_queued < r + RANDOM_ITEMS) begin
         if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 25);
         if (items_queued >= r + RANDOM_ITEMS / 2 && items_queued < r + RANDOM_ITEMS / 2 + 2)
            push_drain();
         n_ticks = $urandom_range(0, 99);
         if (n_ticks < 2) begin
            // refill the whole table with short periods and expire it with two ticks
            for (int c = 0; c < NUM_CHANNELS; c++) push_action(ACT_DELETE, 8'(c), 32'd0);
            for (int c = 0; c < NUM_CHANNELS; c++)
               push_action(ACT_ADD, pick_channel(), 32'($urandom_range(1, 2)));
            push_action(ACT_ADD, pick_channel(), pick_period());
            push_action(ACT_RESUME, pick_channel(), $urandom);
            push_action(ACT_TICK, pick_channel(), $urandom);
            push_action(ACT_TICK, pick_channel(), $urandom);
         end else if (n_ticks < 30) begin
            push_action(ACT_TICK, pick_channel(), $urandom);
         end else if (n_ticks < 55) begin
            push_action(ACT_ADD, 8'($urandom_range(0, 255)), pick_period());
         end else if (n_ticks < 70) begin
            push_action(ACT_FEED, pick_channel(), $urandom);
         end else if (n_ticks < 80) begin
            push_action(ACT_DELETE, pick_channel(), $urandom);
         end else if (n_ticks < 85) begin
            push_action(ACT_SUSPEND, pick_channel(), $urandom);
         end else if (n_ticks < 92) begin
            push_action(ACT_RESUME, pick_channel(), $urandom);
         end else if (n_ticks < 95) begin
            push_action($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, pick_channel(),
                        $urandom);
         end else begin
            repeat ($urandom_range(3, 8)) push_action(ACT_TICK, pick_channel(), $urandom);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (idle_cycles < IDLE_LIMIT &&
             !(action_queue.size() == 0 && !sending && !waiting &&
               expected_reports.size() == 0));

      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multi_channel_watchdog_top: mismatch");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (error_count == 0 && expected_reports.size() == 0) begin
            $display("multi_channel_watchdog_top: match");
         end else begin
            $display("multi_channel_watchdog_top: mismatch");
         end
      end
      $finish;
   end

endmodule
